>>> rtl/emges_pkg.sv
// Shared types, codes, reset values and the grip table of the EMG envelope grip selector.
package emges_pkg;

   localparam int WINDOW_LEN_DEFAULT = 64;

   localparam int FUNC_W      = 2;
   localparam int SAMPLE_W    = 12;
   localparam int ENV_W       = 12;
   localparam int GRIP_W      = 3;
   localparam int PATTERN_W   = 6;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 12;

   localparam logic [FUNC_W-1:0] FUNC_SAMPLE = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_NEXT   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_PREV   = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_ON_THRESHOLD  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFF_THRESHOLD = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLE_OFFSET = 2'd2;

   localparam logic [CSR_DATA_W-1:0] ON_THRESHOLD_RESET  = 12'd500;
   localparam logic [CSR_DATA_W-1:0] OFF_THRESHOLD_RESET = 12'd500;
   localparam logic [CSR_DATA_W-1:0] SAMPLE_OFFSET_RESET = 12'd1396;

   localparam logic [GRIP_W-1:0] GRIP_POWER   = 3'd0;
   localparam logic [GRIP_W-1:0] GRIP_POINT   = 3'd1;
   localparam logic [GRIP_W-1:0] GRIP_PINCH   = 3'd2;
   localparam logic [GRIP_W-1:0] GRIP_HOOK    = 3'd3;
   localparam logic [GRIP_W-1:0] GRIP_LATERAL = 3'd4;
   localparam logic [GRIP_W-1:0] GRIP_PEACE   = 3'd5;

   typedef struct packed {
      logic [FUNC_W-1:0]   func;
      logic [SAMPLE_W-1:0] on_sample;
      logic [SAMPLE_W-1:0] off_sample;
   } emges_req_type;

   typedef struct packed {
      logic [ENV_W-1:0]     on_envelope;
      logic [ENV_W-1:0]     off_envelope;
      logic                 hand_active;
      logic [GRIP_W-1:0]    grip_index;
      logic [PATTERN_W-1:0] finger_pattern;
   } emges_rsp_type;

   // Finger pattern of a grip; codes beyond the table fall back to the power grip.
   function automatic logic [PATTERN_W-1:0] grip_pattern(input logic [GRIP_W-1:0] grip);
      logic [PATTERN_W-1:0] pattern;
      case (grip)
         GRIP_POINT:   pattern = 6'h37;
         GRIP_PINCH:   pattern = 6'h38;
         GRIP_HOOK:    pattern = 6'h0F;
         GRIP_LATERAL: pattern = 6'h1F;
         GRIP_PEACE:   pattern = 6'h33;
         default:      pattern = 6'h3F;
      endcase
      return pattern;
   endfunction

endpackage

>>> rtl/emges_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module emges_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // The read data holds until the next read is issued.
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/emg_envelope_grip_selector.sv
// Top level of the EMG envelope grip selector: sample windows, envelopes, switch and grip.
//
// Usage: the request channel (req_valid, req_stall, req_data) carries one transaction per
// item: an EMG sample pair or a grip-button event. The response channel (rsp_valid,
// rsp_stall, rsp_data) returns exactly one transaction per request, in order, holding the
// two window-mean envelopes, the switch state, the grip index and the finger pattern.
// A request taken passes through stages 1, 2 and 3 and then the response register.
// Throughput is one transaction per cycle while the receiver does not stall. The window
// RAM is read when a sample is taken and written back to that slot as the sample leaves
// stage 1; consecutive samples use successive slots, so never share an entry in flight.
// Both channels of the window live in one RAM, one entry per slot.
// When the receiver stalls, the response register holds its transaction and the
// pipeline keeps taking requests until its three stages are full; only then is
// req_stall raised. A transaction waiting in the response register does not stop
// requests from being taken while a stage is empty.
// Reset is synchronous and there is no clearing pass. The window fills in slot order, so
// a flag that sets at the first wrap of the slot counter makes unwritten slots read as
// zero. Thresholds and the baseline return to their default values; the user is to write
// them through the csr port only while the block is idle; the block does not enforce it.
module emg_envelope_grip_selector #(
   parameter int WINDOW_LEN = emges_pkg::WINDOW_LEN_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  emges_pkg::emges_req_type              req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output emges_pkg::emges_rsp_type              rsp_data,
   input  logic                                  csr_write,
   input  logic [emges_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [emges_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   import emges_pkg::*;

   // Slot counter and running sum widths follow from the window length.
   localparam int SLOT_W      = $clog2(WINDOW_LEN);
   localparam int SUM_W       = $clog2(4095 * WINDOW_LEN + 1);
   localparam int RAM_W       = 2 * SAMPLE_W;
   // Exact division of the running sum by the window length: multiply by a rounded-up
   // reciprocal and keep the high bits. This is exact for every sum of SUM_W bits.
   localparam int RECIP_SHIFT = SUM_W + SLOT_W;
   localparam int RECIP_W     = SUM_W + 1;
   localparam int PROD_W      = SUM_W + RECIP_W;
   localparam logic [63:0] RECIP_FULL =
      ((64'd1 << RECIP_SHIFT) / 64'(WINDOW_LEN)) + 64'd1;
   localparam logic [RECIP_W-1:0] RECIP_VAL = RECIP_FULL[RECIP_W-1:0];
   localparam logic [SLOT_W-1:0]  SLOT_LAST = SLOT_W'(WINDOW_LEN - 1);

   // Configuration registers.
   logic [CSR_DATA_W-1:0] on_threshold_ff,  on_threshold_in;
   logic [CSR_DATA_W-1:0] off_threshold_ff, off_threshold_in;
   logic [CSR_DATA_W-1:0] sample_offset_ff, sample_offset_in;

   // Architectural state outside the RAM.
   logic [SLOT_W-1:0] slot_ff,   slot_in;
   logic              filled_ff, filled_in;
   logic [SUM_W-1:0]  on_sum_ff,  on_sum_in;
   logic [SUM_W-1:0]  off_sum_ff, off_sum_in;
   logic [GRIP_W-1:0] grip_ff,   grip_in;
   logic              active_ff, active_in;

   // Stage 1: rectified samples, waiting for the old window entries.
   logic                s1_valid_ff,    s1_valid_in;
   logic [FUNC_W-1:0]   s1_func_ff,     s1_func_in;
   logic [SAMPLE_W-1:0] s1_on_rect_ff,  s1_on_rect_in;
   logic [SAMPLE_W-1:0] s1_off_rect_ff, s1_off_rect_in;
   logic [SLOT_W-1:0]   s1_slot_ff,     s1_slot_in;
   logic                s1_filled_ff,   s1_filled_in;

   // Stage 2: sums updated, envelopes being computed.
   logic                s2_valid_ff,  s2_valid_in;
   logic                s2_sample_ff, s2_sample_in;
   logic [GRIP_W-1:0]   s2_grip_ff,   s2_grip_in;

   // Stage 3: envelopes ready, switch being evaluated.
   logic                s3_valid_ff,   s3_valid_in;
   logic                s3_sample_ff,  s3_sample_in;
   logic [GRIP_W-1:0]   s3_grip_ff,    s3_grip_in;
   logic [ENV_W-1:0]    s3_on_env_ff,  s3_on_env_in;
   logic [ENV_W-1:0]    s3_off_env_ff, s3_off_env_in;

   // Response register.
   logic                rsp_valid_ff, rsp_valid_in;
   emges_rsp_type       rsp_data_ff,  rsp_data_in;

   // Pipeline flow control.
   logic req_take;
   logic out_free, s3_free, s2_free, s1_free;
   logic s1_move, s2_move, s3_move;
   logic s1_is_sample;

   // Window RAM access.
   logic [RAM_W-1:0]    ram_rd_data;
   logic [SAMPLE_W-1:0] on_old, off_old;
   logic                ram_wr_en;

   // Rectification and envelope arithmetic.
   logic [SAMPLE_W-1:0] on_rect, off_rect;
   logic [PROD_W-1:0]   on_product, off_product;

   // A stage can take a new transaction when it is empty or its own one moves on.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s3_free   = !s3_valid_ff || out_free;
   assign s2_free   = !s2_valid_ff || s3_free;
   assign s1_free   = !s1_valid_ff || s2_free;
   assign s1_move   = s1_valid_ff && s2_free;
   assign s2_move   = s2_valid_ff && s3_free;
   assign s3_move   = s3_valid_ff && out_free;
   assign req_stall = !s1_free;
   assign req_take  = req_valid && s1_free;

   assign s1_is_sample = (s1_func_ff == FUNC_SAMPLE);

   // Absolute difference from the baseline always fits in twelve bits.
   always_comb begin
      if (req_data.on_sample >= sample_offset_ff) begin
         on_rect = req_data.on_sample - sample_offset_ff;
      end else begin
         on_rect = sample_offset_ff - req_data.on_sample;
      end
      if (req_data.off_sample >= sample_offset_ff) begin
         off_rect = req_data.off_sample - sample_offset_ff;
      end else begin
         off_rect = sample_offset_ff - req_data.off_sample;
      end
   end

   // The read is issued as the request is taken; the data is there while it sits in
   // stage 1 and holds until the next request is taken.
   emges_ram #(
      .WIDTH (RAM_W),
      .DEPTH (WINDOW_LEN)
   ) window_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (s1_slot_ff),
      .wr_data ({s1_on_rect_ff, s1_off_rect_ff}),
      .rd_en   (req_take),
      .rd_addr (slot_ff),
      .rd_data (ram_rd_data)
   );

   assign ram_wr_en = s1_move && s1_is_sample;

   // Slots not yet written since reset read as zero.
   assign on_old  = s1_filled_ff ? ram_rd_data[RAM_W-1:SAMPLE_W] : '0;
   assign off_old = s1_filled_ff ? ram_rd_data[SAMPLE_W-1:0]     : '0;

   // The running sums always belong to the newest transaction in stage 2 or beyond, and
   // they only change when stage 2 is free, so stage 2 reads them directly.
   assign on_product  = PROD_W'(on_sum_ff)  * PROD_W'(RECIP_VAL);
   assign off_product = PROD_W'(off_sum_ff) * PROD_W'(RECIP_VAL);

   // Configuration writes; an index past the list is ignored.
   always_comb begin
      on_threshold_in  = on_threshold_ff;
      off_threshold_in = off_threshold_ff;
      sample_offset_in = sample_offset_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_ON_THRESHOLD:  on_threshold_in  = csr_wdata;
            CSR_OFF_THRESHOLD: off_threshold_in = csr_wdata;
            CSR_SAMPLE_OFFSET: sample_offset_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // Slot counter and fill flag advance as a sample is taken.
   always_comb begin
      slot_in   = slot_ff;
      filled_in = filled_ff;
      if (req_take && (req_data.func == FUNC_SAMPLE)) begin
         if (slot_ff == SLOT_LAST) begin
            slot_in   = '0;
            filled_in = 1'b1;
         end else begin
            slot_in = slot_ff + 1'b1;
         end
      end
   end

   always_comb begin
      s1_valid_in    = req_take || (s1_valid_ff && !s2_free);
      s1_func_in     = req_data.func;
      s1_on_rect_in  = on_rect;
      s1_off_rect_in = off_rect;
      s1_slot_in     = slot_ff;
      s1_filled_in   = filled_ff;
   end

   // Stage 1 to stage 2: running sums and grip selection.
   always_comb begin
      on_sum_in  = on_sum_ff;
      off_sum_in = off_sum_ff;
      grip_in    = grip_ff;
      if (s1_move) begin
         unique case (s1_func_ff)
            FUNC_SAMPLE: begin
               on_sum_in  = on_sum_ff - SUM_W'(on_old) + SUM_W'(s1_on_rect_ff);
               off_sum_in = off_sum_ff - SUM_W'(off_old) + SUM_W'(s1_off_rect_ff);
            end
            FUNC_NEXT: begin
               grip_in = (grip_ff < GRIP_PEACE) ? grip_ff + 1'b1 : GRIP_POWER;
            end
            FUNC_PREV: begin
               grip_in = (grip_ff > GRIP_POWER) ? grip_ff - 1'b1 : GRIP_PEACE;
            end
            default: ;
         endcase
      end
      s2_valid_in  = s1_move || (s2_valid_ff && !s3_free);
      s2_sample_in = s1_is_sample;
      s2_grip_in   = grip_in;
   end

   // Stage 2 to stage 3: the envelopes are the high bits of the reciprocal products.
   always_comb begin
      s3_valid_in   = s2_move || (s3_valid_ff && !out_free);
      s3_sample_in  = s2_sample_ff;
      s3_grip_in    = s2_grip_ff;
      s3_on_env_in  = on_product[RECIP_SHIFT +: ENV_W];
      s3_off_env_in = off_product[RECIP_SHIFT +: ENV_W];
   end

   // Stage 3 to the response: the switch makes at most one transition per sample.
   always_comb begin
      active_in = active_ff;
      if (s3_move && s3_sample_ff) begin
         if (!active_ff) begin
            active_in = (s3_on_env_ff > on_threshold_ff);
         end else begin
            active_in = !(s3_off_env_ff > off_threshold_ff);
         end
      end
      rsp_valid_in                = s3_move || (rsp_valid_ff && rsp_stall);
      rsp_data_in.on_envelope     = s3_on_env_ff;
      rsp_data_in.off_envelope    = s3_off_env_ff;
      rsp_data_in.hand_active     = active_in;
      rsp_data_in.grip_index      = s3_grip_ff;
      rsp_data_in.finger_pattern  = active_in ? grip_pattern(s3_grip_ff) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         on_threshold_ff  <= ON_THRESHOLD_RESET;
         off_threshold_ff <= OFF_THRESHOLD_RESET;
         sample_offset_ff <= SAMPLE_OFFSET_RESET;
         slot_ff          <= '0;
         filled_ff        <= 1'b0;
         on_sum_ff        <= '0;
         off_sum_ff       <= '0;
         grip_ff          <= GRIP_POWER;
         active_ff        <= 1'b0;
         s1_valid_ff      <= 1'b0;
         s2_valid_ff      <= 1'b0;
         s3_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         on_threshold_ff  <= on_threshold_in;
         off_threshold_ff <= off_threshold_in;
         sample_offset_ff <= sample_offset_in;
         slot_ff          <= slot_in;
         filled_ff        <= filled_in;
         on_sum_ff        <= on_sum_in;
         off_sum_ff       <= off_sum_in;
         grip_ff          <= grip_in;
         active_ff        <= active_in;
         s1_valid_ff      <= s1_valid_in;
         s2_valid_ff      <= s2_valid_in;
         s3_valid_ff      <= s3_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // Stage payloads load only when a transaction enters the stage.
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_func_ff     <= s1_func_in;
         s1_on_rect_ff  <= s1_on_rect_in;
         s1_off_rect_ff <= s1_off_rect_in;
         s1_slot_ff     <= s1_slot_in;
         s1_filled_ff   <= s1_filled_in;
      end
      if (s1_move) begin
         s2_sample_ff <= s2_sample_in;
         s2_grip_ff   <= s2_grip_in;
      end
      if (s2_move) begin
         s3_sample_ff  <= s3_sample_in;
         s3_grip_ff    <= s3_grip_in;
         s3_on_env_ff  <= s3_on_env_in;
         s3_off_env_ff <= s3_off_env_in;
      end
      if (s3_move) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
